### rtl/core/co_rating_recommender_assert.svh
// Assertion macros shared by the co-rating recommender checkers.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef CO_RATING_RECOMMENDER_ASSERT_SVH
`define CO_RATING_RECOMMENDER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cr_pkg.sv
// Package for the co-rating recommender: field widths, request codes and beat types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cr_pkg;

  localparam int USERS_DEF  = 32;
  localparam int MOVIES_DEF = 32;

  localparam int USER_W  = 5;
  localparam int MOVIE_W = 7;
  // Wide enough to compare a user index against any supported row count.
  localparam int CMP_W   = 9;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_REC = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [USER_W-1:0]  user_index;
    logic [MOVIE_W-1:0] movie_id;
  } req_t;

  typedef struct packed {
    logic [MOVIE_W-1:0] rec_movie;
    logic               is_last;
    logic               is_empty;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/cr_ifs.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on cr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cr_req_if;
  import cr_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

interface cr_res_if;
  import cr_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

`default_nettype wire

### rtl/core/cr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/co_rating_recommender.sv
// Co-rating recommender: a user-by-movie rating bit matrix with a two-hop recommend walk.
// Depends on cr_pkg, cr_ifs (cr_req_if, cr_res_if) and cr_ram.
//
// Usage:
//   req_i carries request beats: an add sets the rating bit for (user_index, movie_id),
//   a recommend asks for every movie rated by a user who shares a rated movie with the
//   asking user, less the asking user's own movies. res_o returns result beats in
//   ascending movie id, the final one with is_last set; an empty set gives one beat
//   with is_empty and is_last set and rec_movie zero.
//   One item is worked on at a time; req_i.ready is high only while idle.
//   An add steps through accept, row read and row write; an out-of-range add is dropped.
//   A recommend reads its own row, then walks all USERS rows through the single RAM
//   read port, one row a cycle, before the movie walk; the movie walk shifts the pick
//   set one bit a cycle while the output register can take a beat.
//   The RAM read port and that one-bit shifter set this pace.
//   Reset clears the per-row valid flags, so every row reads as unrated; the RAM itself
//   is not swept. Results go through an output register: when the receiver stalls, the
//   movie walk holds until the register frees, and the next request is taken only
//   after the walk ends.
`timescale 1ns / 1ps
`default_nettype none

module co_rating_recommender #(
  parameter int USERS  = cr_pkg::USERS_DEF,
  parameter int MOVIES = cr_pkg::MOVIES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cr_req_if.sink   req_i,
  cr_res_if.source res_o
);

  import cr_pkg::*;

  localparam int ROW_W = $clog2(USERS);
  localparam int CNT_W = ROW_W + 1;
  localparam int BIT_W = $clog2(MOVIES);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_ADD_RD  = 8'b0000_0010,
    S_ADD_WR  = 8'b0000_0100,
    S_OWN_RD  = 8'b0000_1000,
    S_OWN_CAP = 8'b0001_0000,
    S_SCAN    = 8'b0010_0000,
    S_PICK    = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [ROW_W-1:0]  user_q, user_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic [MOVIES-1:0] own_q, own_d;
  logic [MOVIES-1:0] reach_q, reach_d;
  logic [MOVIES-1:0] sh_q, sh_d;
  logic [BIT_W-1:0]  cnt_q, cnt_d;
  logic [USERS-1:0]  row_vld_q;
  logic              rvld_q;
  logic              res_vld_q, res_vld_d;
  res_t              res_q, res_d;

  logic              ram_we;
  logic [ROW_W-1:0]  ram_raddr;
  logic [MOVIES-1:0] ram_wdata;
  logic [MOVIES-1:0] ram_rdata;
  logic [MOVIES-1:0] row_eff;
  logic [MOVIES-1:0] picks;
  logic              accept;
  logic              user_ok;
  logic              movie_ok;
  logic              can_load;
  logic              is_last;

  cr_ram #(
    .WIDTH (MOVIES),
    .DEPTH (USERS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (user_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign user_ok     = CMP_W'(req_i.data.user_index) < CMP_W'(USERS);
  assign movie_ok    = (req_i.data.movie_id != '0) &&
                       (req_i.data.movie_id <= MOVIE_W'(MOVIES));

  // A row never written since reset reads as unrated.
  assign row_eff   = ram_rdata & {MOVIES{rvld_q}};
  assign picks     = reach_q & ~own_q;
  assign can_load  = !res_vld_q || res_o.ready;
  assign is_last   = ((sh_q >> 1) == '0);
  assign ram_wdata = row_eff | (MOVIES'(1) << bit_q);
  assign ram_we    = (state_q == S_ADD_WR);

  always_comb begin
    unique case (state_q)
      S_ADD_RD, S_OWN_RD: ram_raddr = user_q;
      default:            ram_raddr = scan_q[ROW_W-1:0];
    endcase
  end

  always_comb begin
    state_d   = state_q;
    user_d    = user_q;
    bit_d     = bit_q;
    scan_d    = scan_q;
    own_d     = own_q;
    reach_d   = reach_q;
    sh_d      = sh_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    res_vld_d = res_vld_q && !res_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          user_d  = ROW_W'(req_i.data.user_index);
          bit_d   = BIT_W'(req_i.data.movie_id - MOVIE_W'(1));
          own_d   = '0;
          reach_d = '0;
          scan_d  = '0;
          if (req_i.data.req_type == REQ_ADD) begin
            if (user_ok && movie_ok) begin
              state_d = S_ADD_RD;
            end
          end else if (user_ok) begin
            state_d = S_OWN_RD;
          end else begin
            state_d = S_PICK;
          end
        end
      end
      S_ADD_RD: begin
        state_d = S_ADD_WR;
      end
      S_ADD_WR: begin
        state_d = S_IDLE;
      end
      S_OWN_RD: begin
        state_d = S_OWN_CAP;
      end
      S_OWN_CAP: begin
        own_d   = row_eff;
        scan_d  = CNT_W'(1);
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // The row arriving now is the one addressed in the previous cycle.
        if ((row_eff & own_q) != '0) begin
          reach_d = reach_q | row_eff;
        end
        if (scan_q == CNT_W'(USERS)) begin
          state_d = S_PICK;
        end else begin
          scan_d = scan_q + CNT_W'(1);
        end
      end
      S_PICK: begin
        if (picks == '0) begin
          if (can_load) begin
            res_d.rec_movie = '0;
            res_d.is_last   = 1'b1;
            res_d.is_empty  = 1'b1;
            res_vld_d       = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          sh_d    = picks;
          cnt_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          if (sh_q[0]) begin
            res_d.rec_movie = MOVIE_W'(cnt_q) + MOVIE_W'(1);
            res_d.is_last   = is_last;
            res_d.is_empty  = 1'b0;
            res_vld_d       = 1'b1;
            if (is_last) begin
              state_d = S_IDLE;
            end
          end
          sh_d  = sh_q >> 1;
          cnt_d = cnt_q + BIT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      scan_q    <= '0;
      cnt_q     <= '0;
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      cnt_q     <= cnt_d;
      rvld_q    <= row_vld_q[ram_raddr];
      res_vld_q <= res_vld_d;
      if (ram_we) begin
        row_vld_q[user_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    user_q  <= user_d;
    bit_q   <= bit_d;
    own_q   <= own_d;
    reach_q <= reach_d;
    sh_q    <= sh_d;
    res_q   <= res_d;
  end

  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

endmodule

`default_nettype wire

### rtl/core/cr_checker.sv
// Port-level checker for the co-rating recommender, bound to the top level.
// Depends on cr_pkg, cr_ifs and co_rating_recommender_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "co_rating_recommender_assert.svh"

module cr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input cr_pkg::req_t   req_data_i,
  input logic           res_valid_i,
  input logic           res_ready_i,
  input cr_pkg::res_t   res_data_i
);

  import cr_pkg::*;

  `CR_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_data_i), "result beat changed while stalled")
  `CR_ASSERT_NOW(a_empty_form, res_valid_i && res_data_i.is_empty, res_data_i.is_last && (res_data_i.rec_movie == '0), "empty beat must be last with movie zero")
  `CR_ASSERT_NOW(a_movie_set, res_valid_i && !res_data_i.is_empty, res_data_i.rec_movie != '0, "non-empty beat carries movie zero")
  `CR_ASSERT_NEXT(a_busy_after_rec, req_valid_i && req_ready_i && (req_data_i.req_type == REQ_REC), !req_ready_i, "request taken while a recommend is in progress")

endmodule

bind co_rating_recommender cr_checker u_cr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_data_i  (req_i.data),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

`default_nettype wire
